/* hdl/triangular_sample_inverse_cdf_top_defines.svh */
// Assertion macros shared by the triangular sampler RTL.
`ifndef TRIANGULAR_SAMPLE_INVERSE_CDF_TOP_DEFINES_SVH
`define TRIANGULAR_SAMPLE_INVERSE_CDF_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks prop at every rising clock edge outside reset.
`define TSIC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks that cons follows whenever ante holds.
`define TSIC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TSIC_ASSERT(label, prop, msg)
`define TSIC_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

/* hdl/tsic_pkg.sv */
// Shared types and constants of the triangular sampler.
package tsic_pkg;

   // Configuration register index.
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_LOW_BOUND  = 2'd0;
   localparam csr_index_type CSR_PEAK_VALUE = 2'd1;
   localparam csr_index_type CSR_HIGH_BOUND = 2'd2;

endpackage

/* hdl/tsic_if.sv */
// Channel interfaces of the triangular sampler: request, response and register write.

interface tsic_req_if #(
   parameter int FRACTION_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] uniform_fraction;

   modport source (output valid, output uniform_fraction, input ready);
   modport sink   (input valid, input uniform_fraction, output ready);
endinterface

interface tsic_rsp_if #(
   parameter int VALUE_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] sample;
   logic                         order_error;

   modport source (output valid, output sample, output order_error, input ready);
   modport sink   (input valid, input sample, input order_error, output ready);
endinterface

interface tsic_csr_if #(
   parameter int VALUE_BITS = 24
);
   import tsic_pkg::*;

   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [VALUE_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/triangular_sample_inverse_cdf_top.sv */
// Top level of the triangular sampler: inverse CDF pipeline with integer square root.
//
//   Channel  Direction  Payload                        Transaction when
//   req_bus  in         uniform_fraction               valid && ready
//   rsp_bus  out        sample, order_error            valid && ready
//   csr_bus  in         index, data (register write)   valid && ready (ready is tied high)
//
// One transaction per clock is accepted and one result per clock is delivered while
// rsp_bus.ready stays high. Items pass six front stages for the differences, the branch
// test and the three-way product, then one root bit per stage of the square-root
// pipeline, then the output register.
// Reset clears the valid bits of every stage and the three bound registers.
// A stage holds while the stage after it is full and stalled; empty stages are refilled,
// so bubbles close up and an empty output register never blocks the request side.
`include "triangular_sample_inverse_cdf_top_defines.svh"

module triangular_sample_inverse_cdf_top #(
   parameter int VALUE_BITS    = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   tsic_req_if.sink  req_bus,
   tsic_rsp_if.source rsp_bus,
   tsic_csr_if.sink  csr_bus
);
   import tsic_pkg::*;

   localparam int VB         = VALUE_BITS;
   localparam int FB         = FRACTION_BITS;
   localparam int MW         = FB + 1;            // width of the fraction multiplier
   localparam int MXW        = MW + VB;           // width of m * x
   localparam int MXL        = (MXW + 1) / 2;     // low slice of m * x
   localparam int MXH        = MXW - MXL;         // high slice of m * x
   localparam int PW         = MXW + VB;          // width of m * x * t
   localparam int RW         = 2 * VB;            // radicand width
   localparam int ROOT_FIRST = 6;
   localparam int OUT_STAGE  = ROOT_FIRST + VB;
   localparam int NUM_STAGES = OUT_STAGE + 1;

   // Configuration registers.
   logic signed [VB-1:0] low_bound_ff;
   logic signed [VB-1:0] peak_value_ff;
   logic signed [VB-1:0] high_bound_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= '0;
         peak_value_ff <= '0;
         high_bound_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_LOW_BOUND:  low_bound_ff  <= csr_bus.data;
            CSR_PEAK_VALUE: peak_value_ff <= csr_bus.data;
            CSR_HIGH_BOUND: high_bound_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Valid bits and per-stage advance chain.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_bus.valid};
   assign adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_bus.ready;

   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_bus.ready = adv[0];

   // Stage 1: bound differences and order check.
   logic signed [VB:0]   d_l;
   logic signed [VB:0]   d_h;
   logic signed [VB:0]   d_t;
   logic                 err_in;
   logic [FB-1:0]        s1_u_ff;
   logic signed [VB-1:0] s1_lo_ff;
   logic signed [VB-1:0] s1_hi_ff;
   logic [VB-1:0]        s1_l_ff;
   logic [VB-1:0]        s1_h_ff;
   logic [VB-1:0]        s1_t_ff;
   logic                 s1_err_ff;

   always_comb begin
      d_l    = {peak_value_ff[VB-1], peak_value_ff} - {low_bound_ff[VB-1], low_bound_ff};
      d_h    = {high_bound_ff[VB-1], high_bound_ff} - {peak_value_ff[VB-1], peak_value_ff};
      d_t    = {high_bound_ff[VB-1], high_bound_ff} - {low_bound_ff[VB-1], low_bound_ff};
      err_in = !((low_bound_ff <= peak_value_ff) && (peak_value_ff <= high_bound_ff));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_u_ff   <= req_bus.uniform_fraction;
         s1_lo_ff  <= low_bound_ff;
         s1_hi_ff  <= high_bound_ff;
         s1_l_ff   <= d_l[VB-1:0];
         s1_h_ff   <= d_h[VB-1:0];
         s1_t_ff   <= d_t[VB-1:0];
         s1_err_ff <= err_in;
      end
   end

   // Stage 2: u * t for the branch test.
   logic [FB+VB-1:0]     s2_ut_ff;
   logic [FB-1:0]        s2_u_ff;
   logic signed [VB-1:0] s2_lo_ff;
   logic signed [VB-1:0] s2_hi_ff;
   logic [VB-1:0]        s2_l_ff;
   logic [VB-1:0]        s2_h_ff;
   logic [VB-1:0]        s2_t_ff;
   logic                 s2_err_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_ut_ff  <= s1_u_ff * s1_t_ff;
         s2_u_ff   <= s1_u_ff;
         s2_lo_ff  <= s1_lo_ff;
         s2_hi_ff  <= s1_hi_ff;
         s2_l_ff   <= s1_l_ff;
         s2_h_ff   <= s1_h_ff;
         s2_t_ff   <= s1_t_ff;
         s2_err_ff <= s1_err_ff;
      end
   end

   // Stage 3: pick the rising or falling side of the distribution.
   // An order error forces x to zero, so the root comes out zero and the sample is low.
   logic                 branch_low;
   logic [MW-1:0]        m_in;
   logic [VB-1:0]        x_in;
   logic signed [VB-1:0] base_in;
   logic                 neg_in;
   logic [MW-1:0]        s3_m_ff;
   logic [VB-1:0]        s3_x_ff;
   logic [VB-1:0]        s3_t_ff;
   logic signed [VB-1:0] s3_base_ff;
   logic                 s3_neg_ff;
   logic                 s3_err_ff;

   always_comb begin
      branch_low = s2_ut_ff < {s2_l_ff, {FB{1'b0}}};
      m_in       = branch_low ? {1'b0, s2_u_ff} : ({1'b1, {FB{1'b0}}} - {1'b0, s2_u_ff});
      x_in       = s2_err_ff ? '0 : (branch_low ? s2_l_ff : s2_h_ff);
      base_in    = (branch_low || s2_err_ff) ? s2_lo_ff : s2_hi_ff;
      neg_in     = !branch_low && !s2_err_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_m_ff    <= m_in;
         s3_x_ff    <= x_in;
         s3_t_ff    <= s2_t_ff;
         s3_base_ff <= base_in;
         s3_neg_ff  <= neg_in;
         s3_err_ff  <= s2_err_ff;
      end
   end

   // Stage 4: m * x.
   logic [MXW-1:0]       s4_mx_ff;
   logic [VB-1:0]        s4_t_ff;
   logic signed [VB-1:0] s4_base_ff;
   logic                 s4_neg_ff;
   logic                 s4_err_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_mx_ff   <= s3_m_ff * s3_x_ff;
         s4_t_ff    <= s3_t_ff;
         s4_base_ff <= s3_base_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_err_ff  <= s3_err_ff;
      end
   end

   // Stage 5: two partial products of (m * x) * t.
   logic [MXL+VB-1:0]    s5_pl_ff;
   logic [MXH+VB-1:0]    s5_ph_ff;
   logic signed [VB-1:0] s5_base_ff;
   logic                 s5_neg_ff;
   logic                 s5_err_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_pl_ff   <= s4_mx_ff[MXL-1:0] * s4_t_ff;
         s5_ph_ff   <= s4_mx_ff[MXW-1:MXL] * s4_t_ff;
         s5_base_ff <= s4_base_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_err_ff  <= s4_err_ff;
      end
   end

   // Stage 6: sum the partial products and drop the fraction bits.
   logic [PW-1:0]        prod;
   logic [RW-1:0]        s6_rad_ff;
   logic signed [VB-1:0] s6_base_ff;
   logic                 s6_neg_ff;
   logic                 s6_err_ff;

   assign prod = {s5_ph_ff, {MXL{1'b0}}} + PW'(s5_pl_ff);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_rad_ff  <= prod[FB +: RW];
         s6_base_ff <= s5_base_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_err_ff  <= s5_err_ff;
      end
   end

   // Square-root pipeline: one root bit per stage, two radicand bits brought down each time.
   logic [RW-1:0]        rt_rad_ff  [VB];
   logic [VB:0]          rt_rem_ff  [VB];
   logic [VB-1:0]        rt_root_ff [VB];
   logic signed [VB-1:0] rt_base_ff [VB];
   logic                 rt_neg_ff  [VB];
   logic                 rt_err_ff  [VB];

   for (genvar j = 0; j < VB; j++) begin : g_root
      logic [RW-1:0]        rad_prev;
      logic [VB:0]          rem_prev;
      logic [VB-1:0]        root_prev;
      logic signed [VB-1:0] base_prev;
      logic                 neg_prev;
      logic                 err_prev;
      logic [VB+2:0]        cur;
      logic [VB+2:0]        trial;
      logic [VB+2:0]        diff;
      logic                 fits;
      logic [VB:0]          rem_in;
      logic [VB-1:0]        root_in;

      if (j == 0) begin : g_head
         assign rad_prev  = s6_rad_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign base_prev = s6_base_ff;
         assign neg_prev  = s6_neg_ff;
         assign err_prev  = s6_err_ff;
      end else begin : g_body
         assign rad_prev  = rt_rad_ff[j-1];
         assign rem_prev  = rt_rem_ff[j-1];
         assign root_prev = rt_root_ff[j-1];
         assign base_prev = rt_base_ff[j-1];
         assign neg_prev  = rt_neg_ff[j-1];
         assign err_prev  = rt_err_ff[j-1];
      end

      // Trial subtract of 4q + 1 from the remainder with two new bits.
      always_comb begin
         cur     = {rem_prev, rad_prev[RW-1 -: 2]};
         trial   = {1'b0, root_prev, 2'b01};
         diff    = cur - trial;
         fits    = cur >= trial;
         rem_in  = fits ? diff[VB:0] : cur[VB:0];
         root_in = {root_prev[VB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (adv[ROOT_FIRST + j]) begin
            rt_rad_ff[j]  <= {rad_prev[RW-3:0], 2'b00};
            rt_rem_ff[j]  <= rem_in;
            rt_root_ff[j] <= root_in;
            rt_base_ff[j] <= base_prev;
            rt_neg_ff[j]  <= neg_prev;
            rt_err_ff[j]  <= err_prev;
         end
      end
   end

   // Output register: apply the root to the chosen bound.
   logic [VB-1:0] sample_in;
   logic [VB-1:0] sample_ff;
   logic          order_error_ff;

   assign sample_in = rt_neg_ff[VB-1] ? (rt_base_ff[VB-1] - rt_root_ff[VB-1])
                                      : (rt_base_ff[VB-1] + rt_root_ff[VB-1]);

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         sample_ff      <= sample_in;
         order_error_ff <= rt_err_ff[VB-1];
      end
   end

   assign rsp_bus.valid       = valid_ff[OUT_STAGE];
   assign rsp_bus.sample      = sample_ff;
   assign rsp_bus.order_error = order_error_ff;

   // An empty output register lets every stage move, so the request side is open.
   `TSIC_ASSERT_IMPL(a_empty_out_opens_req, !valid_ff[OUT_STAGE], req_bus.ready, "request blocked with empty output")
   // Items with bounds out of order reach the last root stage with a zero root.
   `TSIC_ASSERT_IMPL(a_error_zero_root, valid_ff[OUT_STAGE-1] && rt_err_ff[VB-1], rt_root_ff[VB-1] == '0, "nonzero root on order error")
   // The final remainder never exceeds twice the root.
   `TSIC_ASSERT_IMPL(a_root_remainder, valid_ff[OUT_STAGE-1], rt_rem_ff[VB-1] <= {rt_root_ff[VB-1], 1'b0}, "square-root remainder out of range")
   // A stalled stage in front of a stalled output keeps its item.
   `TSIC_ASSERT(a_stall_holds_last_root, !(valid_ff[OUT_STAGE-1] && valid_ff[OUT_STAGE] && !rsp_bus.ready) || !adv[OUT_STAGE-1], "root stage advanced into a stalled output")

endmodule
